### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the text sanitiser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/uts_pkg.sv
// ----------------------------------------------------------------------------
// Text sanitiser package
// Shared types and constants for the UTF-8 text sanitiser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package uts_pkg;

    // Depth of the job queue between the front and back parts.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Byte classes.
    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7E;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF7;
    localparam logic [1:0] CONT_TAG = 2'b10;

    // Sequence lengths.
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    // One job: the bytes released by one input beat.
    typedef struct packed {
        logic [3:0][7:0] data;  // bytes in output order
        logic [2:0]      num;   // number of bytes, zero for a bare end marker
        logic            last;  // the beat closed the text
    } t_job;

    // Write side of the job queue.
    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

### hw/rtl/uts_front.sv
// ----------------------------------------------------------------------------
// Sanitiser front part
// Accepts input beats, classifies each byte, tracks the pending UTF-8
// sequence and pushes one job per beat that releases bytes or ends the text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module uts_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [7:0]     i_in_byte,
    input  wire logic           i_text_last,
    input  wire uts_pkg::t_q_stat i_q_stat,
    output logic                o_stall,
    output uts_pkg::t_push      o_push
);
    import uts_pkg::*;

    logic [7:0] r_held [0:2];
    logic [7:0] n_held [0:2];
    logic [1:0] r_held_count, n_held_count;
    logic [2:0] r_exp_len, n_exp_len;

    logic       accept;
    logic       pending;
    logic       is_cont;
    logic       fresh;
    logic [2:0] copy_cnt;
    logic [2:0] num;
    t_job       job;

    assign o_stall = i_q_stat.full;
    assign accept  = i_valid && !i_q_stat.full;
    assign pending = (r_exp_len != LEN_NONE);
    assign is_cont = (i_in_byte[7:6] == CONT_TAG);

    // Sequence tracking and classification of the incoming byte.
    always_comb begin
        n_held       = r_held;
        n_held_count = r_held_count;
        n_exp_len    = r_exp_len;
        fresh        = 1'b1;
        copy_cnt     = 3'd0;
        num          = 3'd0;

        if (pending) begin
            if (is_cont) begin
                fresh = 1'b0;
                if (({1'b0, r_held_count} + 3'd1) >= r_exp_len) begin
                    // The sequence is complete: release held bytes and this one.
                    copy_cnt     = {1'b0, r_held_count};
                    num          = {1'b0, r_held_count} + 3'd1;
                    n_held_count = 2'd0;
                    n_exp_len    = LEN_NONE;
                end else if (r_held_count != 2'd3) begin
                    n_held[r_held_count] = i_in_byte;
                    n_held_count         = r_held_count + 2'd1;
                end else begin
                    n_held_count = 2'd0;
                    n_exp_len    = LEN_NONE;
                end
            end else begin
                // A broken sequence is dropped; the byte is judged afresh.
                n_held_count = 2'd0;
                n_exp_len    = LEN_NONE;
            end
        end

        if (fresh) begin
            if (i_in_byte inside {[PRINT_LO:PRINT_HI], CH_TAB, CH_LF, CH_CR}) begin
                num = 3'd1;
            end else if (i_in_byte inside {[LEAD2_LO:LEAD2_HI]}) begin
                n_held[0]    = i_in_byte;
                n_held_count = 2'd1;
                n_exp_len    = LEN_2;
            end else if (i_in_byte inside {[LEAD3_LO:LEAD3_HI]}) begin
                n_held[0]    = i_in_byte;
                n_held_count = 2'd1;
                n_exp_len    = LEN_3;
            end else if (i_in_byte inside {[LEAD4_LO:LEAD4_HI]}) begin
                n_held[0]    = i_in_byte;
                n_held_count = 2'd1;
                n_exp_len    = LEN_4;
            end
        end

        // End of text drops whatever is still pending.
        if (i_text_last) begin
            n_held_count = 2'd0;
            n_exp_len    = LEN_NONE;
        end
    end

    // Job assembly: held bytes first, then the current byte.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            job.data[i] = (3'(i) < copy_cnt) ? r_held[i] : i_in_byte;
        end
        job.data[3] = i_in_byte;
        job.num     = num;
        job.last    = i_text_last;
    end

    assign o_push.valid = accept && ((num != 3'd0) || i_text_last);
    assign o_push.job   = job;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count <= 2'd0;
            r_exp_len    <= LEN_NONE;
        end else if (accept) begin
            r_held_count <= n_held_count;
            r_exp_len    <= n_exp_len;
        end
    end

    // Held bytes carry no reset; only entries below the count are read.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

    `ASSERT_IMPLIES(a_idle_no_held, i_clk, i_rst_n, r_exp_len == LEN_NONE,
        r_held_count == 2'd0, "held bytes without a pending sequence")
    `ASSERT_IMPLIES(a_len_range, i_clk, i_rst_n, 1'b1,
        r_exp_len <= LEN_4, "pending sequence length out of range")

endmodule

`default_nettype wire

### hw/rtl/uts_queue.sv
// ----------------------------------------------------------------------------
// Sanitiser job queue
// Short first-in first-out queue of jobs between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module uts_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire uts_pkg::t_push i_push,
    input  wire logic           i_pop,
    output uts_pkg::t_job       o_head,
    output uts_pkg::t_q_stat    o_stat
);
    import uts_pkg::*;

    t_job            r_mem [0:Q_DEPTH-1];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push.valid, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_IMPLIES(a_no_overflow, i_clk, i_rst_n, o_stat.full,
        !i_push.valid, "job pushed into a full queue")
    `ASSERT_IMPLIES(a_no_underflow, i_clk, i_rst_n, o_stat.empty,
        !i_pop, "job popped from an empty queue")

endmodule

`default_nettype wire

### hw/rtl/uts_back.sv
// ----------------------------------------------------------------------------
// Sanitiser back part
// Walks the job at the head of the queue one byte per cycle, unless the output is
// stalled, into the output register and pops the job with its final beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module uts_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire uts_pkg::t_job    i_head,
    input  wire uts_pkg::t_q_stat i_q_stat,
    input  wire logic             i_stall,
    output logic                  o_pop,
    output logic                  o_valid,
    output logic [7:0]            o_out_byte,
    output logic                  o_byte_present,
    output logic                  o_run_last,
    output logic                  o_text_end
);
    import uts_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_present;
    logic       r_run_last;
    logic       r_text_end;

    logic       fire;
    logic       present;
    logic       run_last;

    // A beat is produced whenever a job waits and the output register frees up.
    assign fire     = !i_q_stat.empty && (!r_valid || !i_stall);
    assign present  = (i_head.num != 3'd0);
    assign run_last = !present || (({1'b0, r_idx} + 3'd1) == i_head.num);
    assign o_pop    = fire && run_last;

    // Position within the current job.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (fire) begin
            r_idx <= run_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (fire) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_byte     <= present ? i_head.data[r_idx] : 8'h00;
            r_present  <= present;
            r_run_last <= run_last;
            r_text_end <= run_last && i_head.last;
        end
    end

    assign o_valid        = r_valid;
    assign o_out_byte     = r_byte;
    assign o_byte_present = r_present;
    assign o_run_last     = r_run_last;
    assign o_text_end     = r_text_end;

    `ASSERT_IMPLIES(a_marker_ends_text, i_clk, i_rst_n, r_valid && !r_present,
        r_run_last && r_text_end && (r_byte == 8'h00), "malformed end marker")

endmodule

`default_nettype wire

### hw/rtl/utf8_text_sanitizer_unit.sv
// A released byte passes through a job queue entry and then the output register.
// Throughput: one input beat per cycle while the job queue has room; one output byte per
// cycle unless the output is stalled. A beat completing a UTF-8 sequence of n bytes gives
// n output beats, buffered by a four-entry job queue; the input stalls only while it is full.
// Reset is synchronous and active low; it clears the pending sequence, queue and output.
// ----------------------------------------------------------------------------
// UTF-8 text sanitiser
// Passes printable ASCII, TAB, LF, CR and complete UTF-8 sequences of a
// byte stream and drops everything else, marking the end of each text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_text_sanitizer_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_text_last,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_present,
    output logic            o_run_last,
    output logic            o_text_end
);
    import uts_pkg::*;

    t_push   push;
    t_job    head;
    t_q_stat q_stat;
    logic    pop;

    // Classification and sequence tracking.
    uts_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_in_byte   (i_in_byte),
        .i_text_last (i_text_last),
        .i_q_stat    (q_stat),
        .o_stall     (o_stall),
        .o_push      (push)
    );

    // Job queue between the two sides.
    uts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // Byte-per-cycle output stage, paused while the output is stalled.
    uts_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_q_stat       (q_stat),
        .i_stall        (i_stall),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_out_byte     (o_out_byte),
        .o_byte_present (o_byte_present),
        .o_run_last     (o_run_last),
        .o_text_end     (o_text_end)
    );

endmodule

`default_nettype wire

### test/tb_utf8_text_sanitizer_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the UTF-8 text sanitiser
// Streams directed and random texts into the sanitiser, predicts the cleaned
// bytes and end markers of every input beat, and checks each output beat in
// order against them while both sides idle and stall at random outside one gap-free stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_utf8_text_sanitizer_unit;

    import uts_pkg::*;

    // One output beat as the sanitiser should present it.
    typedef struct {
        logic [7:0] ch;
        logic       present;
        logic       run_last;
        logic       text_end;
    } t_clean_beat;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_in_byte   = 8'h00;
    logic       i_text_last = 1'b0;
    logic       i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_byte_present;
    logic       o_run_last;
    logic       o_text_end;

    // Predictor state: the partly received UTF-8 sequence.
    logic [7:0]  held_seq [3];
    logic [1:0]  held_cnt  = 2'd0;
    logic [2:0]  seq_len   = LEN_NONE;

    t_clean_beat clean_text_q [$];
    int          error_count = 0;
    int          beats_sent  = 0;
    bit          sender_gaps = 1'b1;
    bit          stall_gaps  = 1'b1;

    utf8_text_sanitizer_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_byte      (i_in_byte),
        .i_text_last    (i_text_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_byte_present (o_byte_present),
        .o_run_last     (o_run_last),
        .o_text_end     (o_text_end)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Work out the output beats released by one accepted input beat.
    function automatic void sanitize_beat(input logic [7:0] b, input logic last);
        logic [7:0]  released [4];
        int          n;
        bit          fresh;
        t_clean_beat cb;
        n     = 0;
        fresh = 1'b1;

        // A pending sequence either grows, completes or is broken.
        if (seq_len != LEN_NONE) begin
            if (b[7:6] == CONT_TAG) begin
                fresh = 1'b0;
                if (int'(held_cnt) + 1 >= int'(seq_len)) begin
                    for (int k = 0; k < int'(held_cnt) && k < 3; k++) begin
                        released[n] = held_seq[k];
                        n++;
                    end
                    released[n] = b;
                    n++;
                    held_cnt = 2'd0;
                    seq_len  = LEN_NONE;
                end else if (held_cnt < 2'd3) begin
                    held_seq[held_cnt] = b;
                    held_cnt = held_cnt + 2'd1;
                end else begin
                    held_cnt = 2'd0;
                    seq_len  = LEN_NONE;
                end
            end else begin
                held_cnt = 2'd0;
                seq_len  = LEN_NONE;
            end
        end

        // A byte not absorbed by a sequence is judged on its own.
        if (fresh) begin
            if ((b >= PRINT_LO && b <= PRINT_HI) || b == CH_TAB || b == CH_LF
                    || b == CH_CR) begin
                released[n] = b;
                n++;
            end else if (b >= LEAD2_LO && b <= LEAD4_HI) begin
                held_seq[0] = b;
                held_cnt    = 2'd1;
                if (b <= LEAD2_HI)
                    seq_len = LEN_2;
                else if (b <= LEAD3_HI)
                    seq_len = LEN_3;
                else
                    seq_len = LEN_4;
            end
        end

        // The end of a text discards anything still held.
        if (last) begin
            held_cnt = 2'd0;
            seq_len  = LEN_NONE;
        end

        if (n == 0) begin
            if (last) begin
                cb = '{ch: 8'h00, present: 1'b0, run_last: 1'b1, text_end: 1'b1};
                clean_text_q = {clean_text_q, cb};
            end
        end else begin
            for (int k = 0; k < n; k++) begin
                cb.ch       = released[k];
                cb.present  = 1'b1;
                cb.run_last = (k == n - 1);
                cb.text_end = (k == n - 1) && last;
                clean_text_q = {clean_text_q, cb};
            end
        end
    endfunction

    // Present one input beat, hold it until accepted, then predict its output.
    task automatic send_beat(input logic [7:0] b, input logic last);
        if (sender_gaps && $urandom_range(0, 99) < 15) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_in_byte   <= b;
        i_text_last <= last;
        do @(posedge i_clk); while (o_stall);
        sanitize_beat(b, last);
        beats_sent++;
    endtask

    // Stop sending and let every predicted beat arrive.
    task automatic drain_output();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (clean_text_q.size() != 0) @(posedge i_clk);
    endtask

    // Compare one output beat with the oldest prediction.
    task automatic check_clean_beat();
        t_clean_beat exp_beat;
        if (clean_text_q.size() == 0) begin
            $error("unexpected output beat: out_byte %0h present %0b",
                   o_out_byte, o_byte_present);
            error_count++;
        end else begin
            exp_beat = clean_text_q.pop_front();
            if (o_out_byte !== exp_beat.ch) begin
                $error("out_byte: expected %0h, got %0h", exp_beat.ch, o_out_byte);
                error_count++;
            end
            if (o_byte_present !== exp_beat.present) begin
                $error("byte_present: expected %0b, got %0b",
                       exp_beat.present, o_byte_present);
                error_count++;
            end
            if (o_run_last !== exp_beat.run_last) begin
                $error("run_last: expected %0b, got %0b", exp_beat.run_last, o_run_last);
                error_count++;
            end
            if (o_text_end !== exp_beat.text_end) begin
                $error("text_end: expected %0b, got %0b", exp_beat.text_end, o_text_end);
                error_count++;
            end
        end
    endtask

    // Output side: take beats when not stalling and stall at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall)
                check_clean_beat();
            i_stall <= stall_gaps && ($urandom_range(0, 99) < 15);
        end
    end

    // Append one random token: mostly well-formed text, some broken or noise.
    function automatic void append_token(ref logic [7:0] txt [$]);
        int r;
        int len;
        int conts;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            txt = {txt, 8'($urandom_range(PRINT_LO, PRINT_HI))};
        end else if (r < 50) begin
            case ($urandom_range(0, 2))
                0: txt = {txt, CH_TAB};
                1: txt = {txt, CH_LF};
                default: txt = {txt, CH_CR};
            endcase
        end else if (r < 90) begin
            len = $urandom_range(2, 4);
            case (len)
                2: txt = {txt, 8'($urandom_range(LEAD2_LO, LEAD2_HI))};
                3: txt = {txt, 8'($urandom_range(LEAD3_LO, LEAD3_HI))};
                default: txt = {txt, 8'($urandom_range(LEAD4_LO, LEAD4_HI))};
            endcase
            // Broken sequences stop short of their full length.
            conts = (r < 80) ? len - 1 : $urandom_range(0, len - 2);
            repeat (conts) txt = {txt, 8'h80 | 8'($urandom_range(0, 63))};
        end else begin
            txt = {txt, 8'($urandom_range(0, 255))};
        end
    endfunction

    // Send random texts until the given number of beats has gone out.
    task automatic test_random_texts(input int n_beats);
        logic [7:0] txt [$];
        int         target;
        target = beats_sent + n_beats;
        while (beats_sent < target) begin
            txt.delete();
            repeat ($urandom_range(1, 8)) append_token(txt);
            foreach (txt[k])
                send_beat(txt[k], k == txt.size() - 1);
        end
    endtask

    // Control bytes, whitespace and the printable range limits.
    task automatic test_ascii_classes();
        send_beat(8'h00, 1'b0);
        send_beat(CH_TAB, 1'b0);
        send_beat(CH_LF, 1'b0);
        send_beat(CH_CR, 1'b0);
        send_beat(8'h1F, 1'b0);
        send_beat(PRINT_LO, 1'b0);
        send_beat(PRINT_HI, 1'b0);
        send_beat(8'h7F, 1'b0);
    endtask

    // Complete two-, three- and four-byte sequences at the lead extremes.
    task automatic test_full_sequences();
        send_beat(LEAD2_LO, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(LEAD3_HI, 1'b0);
        send_beat(8'hBF, 1'b0);
        send_beat(8'hBF, 1'b0);
        send_beat(LEAD4_HI, 1'b0);
        send_beat(8'hBF, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'hBF, 1'b0);
    endtask

    // Overlong lead with its stray continuation, and invalid leads.
    task automatic test_dropped_leads();
        send_beat(8'hC0, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'hF8, 1'b0);
        send_beat(8'hFF, 1'b0);
    endtask

    // A sequence broken by a plain character, which must still come through.
    task automatic test_broken_sequence();
        send_beat(8'hE2, 1'b0);
        send_beat(8'h82, 1'b0);
        send_beat(8'h41, 1'b0);
    endtask

    // End of text with a sequence pending, then a text of one dropped byte and one of a kept byte.
    task automatic test_text_end();
        send_beat(8'hF4, 1'b0);
        send_beat(8'h8F, 1'b1);
        send_beat(8'hC1, 1'b1);
        send_beat(8'h7A, 1'b1);
    endtask

    // Hold the sender back until the output has caught up, then carry on.
    task automatic test_drain_pause();
        drain_output();
        test_random_texts(40);
    endtask

    // A long stretch with both sides running flat out.
    task automatic test_no_gaps();
        sender_gaps = 1'b0;
        stall_gaps  = 1'b0;
        test_random_texts(60);
        sender_gaps = 1'b1;
        stall_gaps  = 1'b1;
    endtask

    // Overall time limit.
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Stimulus sequence.
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ascii_classes();
        test_full_sequences();
        test_dropped_leads();
        test_broken_sequence();
        test_text_end();
        test_random_texts(70);
        test_drain_pause();
        test_no_gaps();
        test_random_texts(40);

        drain_output();
        repeat (10) @(posedge i_clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
